FILE: rtl/bfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfd_pkg;

	// Image geometry limits.
	localparam int POS_W        = 12;
	localparam int MAX_WIDTH    = 1 << POS_W;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int MAX_FACTOR   = 16;

	// Register widths and reset values.
	localparam int FACT_W     = 5;
	localparam int DIM_W      = 13;
	localparam int RST_FACTOR = 8;
	localparam int RST_WIDTH  = 4096;
	localparam int RST_HEIGHT = 4096;

	// Position inside a block, and block-end products of the front end.
	localparam int SUB_W  = $clog2(MAX_FACTOR);
	localparam int PROD_W = POS_W + 1 + FACT_W;

	// Channel sums, with headroom for blocks disturbed by a mid-frame factor change.
	localparam int SUM_W  = 20;
	localparam int DIV_W  = 16;
	localparam int RCP_W  = 25;
	localparam int RCP_SH = 24;
	localparam int MULT_W = DIV_W + RCP_W;

	localparam int CMDQ_DEPTH = 4;
	localparam int OUTQ_DEPTH = 8;

	typedef enum logic [1:0] {
		REG_SCALE  = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       red_out;
		logic [7:0]       green_out;
		logic [7:0]       blue_out;
		logic [POS_W-1:0] out_column;
		logic [POS_W-1:0] out_row;
		logic             end_of_line;
	} out_item_t;

	typedef struct packed {
		logic [FACT_W-1:0] n;
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
	} cfg_t;

	// One in-range pixel, as handed from the front end to the accumulator.
	typedef struct packed {
		logic [POS_W-1:0]  addr;
		logic              first;
		logic              emit;
		logic              eol;
		logic [POS_W-1:0]  row;
		logic [2:0][7:0]   px;
	} cmd_t;

	function automatic logic [FACT_W-1:0] clamp_factor(logic [FACT_W-1:0] v);
		if (v == '0) begin
			return FACT_W'(1);
		end else if (v > FACT_W'(MAX_FACTOR)) begin
			return FACT_W'(MAX_FACTOR);
		end
		return v;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
		if (v == '0) begin
			return DIM_W'(1);
		end else if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// ceil(2^24 / (n*n)): exact floor division by the block area for sums below 2^16.
	function automatic logic [RCP_W-1:0] recip(logic [FACT_W-1:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			5'd1:    r = 25'd16777216;
			5'd2:    r = 25'd4194304;
			5'd3:    r = 25'd1864136;
			5'd4:    r = 25'd1048576;
			5'd5:    r = 25'd671089;
			5'd6:    r = 25'd466034;
			5'd7:    r = 25'd342393;
			5'd8:    r = 25'd262144;
			5'd9:    r = 25'd207127;
			5'd10:   r = 25'd167773;
			5'd11:   r = 25'd138655;
			5'd12:   r = 25'd116509;
			5'd13:   r = 25'd99274;
			5'd14:   r = 25'd85599;
			5'd15:   r = 25'd74566;
			5'd16:   r = 25'd65536;
			default: r = 25'd16777216;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bfd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bfd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bfd_pkg::cfg_t    cfg,
	input  wire logic             take,
	input  wire bfd_pkg::in_item_t pixel,
	output logic                  cmd_push,
	output bfd_pkg::cmd_t         cmd
);
	import bfd_pkg::*;

	logic [SUB_W-1:0] cib_q, rib_q, cib, rib, cib_d, rib_d, nm1;
	logic [POS_W-1:0] bc_q, sc_q, band_q, bc, sc, band, bc_d, sc_d, band_d;
	logic [SUB_W:0]   cib_inc, rib_inc;
	logic [POS_W:0]   sc_inc;
	logic [PROD_W-1:0] col_end, row_end, next_end;
	logic             col_ok, row_ok;

	always_comb begin
		// A frame start clears the position before this pixel is placed.
		cib  = pixel.frame_start ? '0 : cib_q;
		rib  = pixel.frame_start ? '0 : rib_q;
		bc   = pixel.frame_start ? '0 : bc_q;
		sc   = pixel.frame_start ? '0 : sc_q;
		band = pixel.frame_start ? '0 : band_q;

		// A block or band is complete when its far edge lies inside the image.
		col_end  = (PROD_W'(bc) + PROD_W'(1)) * PROD_W'(cfg.n);
		row_end  = (PROD_W'(band) + PROD_W'(1)) * PROD_W'(cfg.n);
		next_end = col_end + PROD_W'(cfg.n);
		col_ok   = col_end <= PROD_W'(cfg.w);
		row_ok   = row_end <= PROD_W'(cfg.h);
		nm1      = SUB_W'(cfg.n - FACT_W'(1));

		cmd_push   = take && col_ok && row_ok;
		cmd.addr   = bc;
		cmd.first  = (cib == '0) && (rib == '0);
		cmd.emit   = (cib == nm1) && (rib == nm1);
		cmd.eol    = next_end > PROD_W'(cfg.w);
		cmd.row    = band;
		cmd.px     = {pixel.red_in, pixel.green_in, pixel.blue_in};

		cib_inc = {1'b0, cib} + (SUB_W+1)'(1);
		rib_inc = {1'b0, rib} + (SUB_W+1)'(1);
		sc_inc  = {1'b0, sc} + (POS_W+1)'(1);
		rib_d   = rib;
		band_d  = band;
		if ((FACT_W)'(cib_inc) >= cfg.n) begin
			cib_d = '0;
			bc_d  = bc + POS_W'(1);
		end else begin
			cib_d = cib_inc[SUB_W-1:0];
			bc_d  = bc;
		end
		if (DIM_W'(sc_inc) >= cfg.w) begin
			sc_d  = '0;
			cib_d = '0;
			bc_d  = '0;
			if ((FACT_W)'(rib_inc) >= cfg.n) begin
				rib_d = '0;
				// The band index sticks at its top code once it gets there.
				if (row_ok && band != '1) begin
					band_d = band + POS_W'(1);
				end
			end else begin
				rib_d = rib_inc[SUB_W-1:0];
			end
		end else begin
			sc_d = sc_inc[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cib_q  <= '0;
			rib_q  <= '0;
			bc_q   <= '0;
			sc_q   <= '0;
			band_q <= '0;
		end else if (take) begin
			cib_q  <= cib_d;
			rib_q  <= rib_d;
			bc_q   <= bc_d;
			sc_q   <= sc_d;
			band_q <= band_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bfd_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module bfd_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bfd_pkg::cmd_t din,
	output logic               full,
	input  wire logic          pop,
	output bfd_pkg::cmd_t      dout,
	output logic               empty
);
	import bfd_pkg::*;

	localparam int PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             slot_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == CNT_W'(CMDQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bfd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bfd_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [bfd_pkg::FACT_W-1:0] factor,
	input  wire logic                       cmd_empty,
	input  wire bfd_pkg::cmd_t              cmd,
	output logic                            cmd_pop,
	input  wire logic                       pop,
	output logic                            empty,
	output bfd_pkg::out_item_t              result
);
	import bfd_pkg::*;

	localparam int OPTR_W = $clog2(OUTQ_DEPTH);
	localparam int OCNT_W = $clog2(OUTQ_DEPTH + 1);

	// Accumulator memory, one entry of three channel sums per output column.
	logic [2:0][SUM_W-1:0] sums_mem [MAX_WIDTH];

	logic                  vld_s1;
	cmd_t                  cmd_s1;
	logic [2:0][SUM_W-1:0] rdata_s1;
	logic [2:0][SUM_W-1:0] base, acc_new;
	logic                  fwd;

	logic                  wb_vld_q;
	logic [POS_W-1:0]      wb_addr_q;
	logic [2:0][SUM_W-1:0] wb_data_q;

	logic                   vld_s2;
	logic [2:0][MULT_W-1:0] prod_s2;
	logic [2:0]             ovf_s2;
	logic [POS_W-1:0]       col_s2, row_s2;
	logic                   eol_s2;
	logic [RCP_W-1:0]       rcp;
	logic [2:0][7:0]        mean;
	logic [MULT_W-RCP_SH-1:0] quo;

	out_item_t              outq_q [OUTQ_DEPTH];
	out_item_t              out_item;
	logic [OPTR_W-1:0]      owr_q, ord_q;
	logic [OCNT_W-1:0]      outq_cnt_q, rsv_q;
	logic                   out_pop, rsv_inc;

	// Room in the result queue is reserved when a block-completing pixel leaves
	// the command queue, so nothing past that point ever has to stall.
	assign cmd_pop = !cmd_empty && (!cmd.emit || rsv_q < OCNT_W'(OUTQ_DEPTH));
	assign rsv_inc = cmd_pop && cmd.emit;
	assign out_pop = pop && !empty;
	assign empty   = outq_cnt_q == '0;
	assign result  = outq_q[ord_q];
	assign rcp     = recip(factor);

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			rdata_s1 <= sums_mem[cmd.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			sums_mem[cmd_s1.addr] <= acc_new;
		end
	end

	always_comb begin
		// The memory read misses the write of the pixel just ahead; take it from
		// the write-back register instead.
		fwd = wb_vld_q && (wb_addr_q == cmd_s1.addr);
		if (cmd_s1.first) begin
			base = '0;
		end else if (fwd) begin
			base = wb_data_q;
		end else begin
			base = rdata_s1;
		end
		for (int c = 0; c < 3; c++) begin
			acc_new[c] = base[c] + SUM_W'(cmd_s1.px[c]);
		end
	end

	always_comb begin
		quo = '0;
		for (int c = 0; c < 3; c++) begin
			quo = prod_s2[c][MULT_W-1:RCP_SH];
			if (ovf_s2[c] || quo > (MULT_W-RCP_SH)'(255)) begin
				mean[c] = 8'hFF;
			end else begin
				mean[c] = quo[7:0];
			end
		end
		out_item.red_out     = mean[2];
		out_item.green_out   = mean[1];
		out_item.blue_out    = mean[0];
		out_item.out_column  = col_s2;
		out_item.out_row     = row_s2;
		out_item.end_of_line = eol_s2;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1 <= cmd;
		end
		if (vld_s1) begin
			wb_addr_q <= cmd_s1.addr;
			wb_data_q <= acc_new;
		end
		if (vld_s1 && cmd_s1.emit) begin
			for (int c = 0; c < 3; c++) begin
				prod_s2[c] <= MULT_W'(acc_new[c][DIV_W-1:0]) * MULT_W'(rcp);
				ovf_s2[c]  <= |acc_new[c][SUM_W-1:DIV_W];
			end
			col_s2 <= cmd_s1.addr;
			row_s2 <= cmd_s1.row;
			eol_s2 <= cmd_s1.eol;
		end
		if (vld_s2) begin
			outq_q[owr_q] <= out_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			wb_vld_q   <= 1'b0;
			vld_s2     <= 1'b0;
			owr_q      <= '0;
			ord_q      <= '0;
			outq_cnt_q <= '0;
			rsv_q      <= '0;
		end else begin
			vld_s1   <= cmd_pop;
			wb_vld_q <= vld_s1;
			vld_s2   <= vld_s1 && cmd_s1.emit;
			if (vld_s2) begin
				owr_q <= owr_q + OPTR_W'(1);
			end
			if (out_pop) begin
				ord_q <= ord_q + OPTR_W'(1);
			end
			if (vld_s2 && !out_pop) begin
				outq_cnt_q <= outq_cnt_q + OCNT_W'(1);
			end else if (out_pop && !vld_s2) begin
				outq_cnt_q <= outq_cnt_q - OCNT_W'(1);
			end
			if (rsv_inc && !out_pop) begin
				rsv_q <= rsv_q + OCNT_W'(1);
			end else if (out_pop && !rsv_inc) begin
				rsv_q <= rsv_q - OCNT_W'(1);
			end
		end
	end

`ifndef SYNTH
	a_rsv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsv_q <= OCNT_W'(OUTQ_DEPTH))
		else $error("result reservations exceed the result queue depth");

	a_cnt_le_rsv: assert property (@(posedge clk) disable iff (!arst_n)
		outq_cnt_q <= rsv_q)
		else $error("result queue holds a beat that was never reserved");

	a_outq_room: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> outq_cnt_q < OCNT_W'(OUTQ_DEPTH))
		else $error("divider wrote into a full result queue");

	a_emit_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(vld_s1))
		else $error("divider stage became valid without an accumulate beat");
`endif

endmodule

`default_nettype wire

FILE: rtl/box_filter_downsample.sv
`timescale 1ns / 1ps
`default_nettype none

// Box-filter downsampler for an RGB raster stream.
// Pixels enter on a queue-style port: a beat is taken on a clock edge with push high
// and full low. frame_start on a beat clears the position counters for that pixel.
// Averaged pixels leave on a second queue-style port: the oldest result sits on
// result while empty is low, and pop with empty low takes it.
// Configuration uses its own valid/ready channel (index 0 factor, 1 width, 2 height);
// cfg_ready is always high and a write takes effect for the next pixel.
// Throughput is one pixel per clock while full is low. The front end places each pixel
// and hands the in-range ones to a four-entry command queue; the back end does one
// read-modify-write of the column accumulator memory per cycle while it is not holding
// a block-completing command, forwarding the previous sum when two consecutive pixels
// hit the same column. A result passes from the beat that completes its block through
// the command queue, accumulate, reciprocal multiply, then the saturating quotient into
// an eight-entry result queue.
// When the receiver stalls, the back end keeps taking commands until eight results are
// waiting or in flight, then holds a block-completing command at the head of the
// command queue; that queue fills and full rises in the cycle after its fourth entry.
// Reset clears all counters and queues and loads factor 8, width and height 4096.
// The accumulator memory is not cleared: each block restarts its sums at its first pixel.

module box_filter_downsample (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire bfd_pkg::in_item_t         pixel,
	output logic                           empty,
	input  wire logic                      pop,
	output bfd_pkg::out_item_t             result,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [bfd_pkg::DIM_W-1:0] cfg_data
);
	import bfd_pkg::*;

	logic [FACT_W-1:0] factor_q;
	logic [DIM_W-1:0]  width_q, height_q;
	cfg_t              cfg;
	logic              take, cmd_push, cmd_pop, cmd_empty;
	cmd_t              cmd_in, cmd_out;

	assign cfg_ready = 1'b1;
	assign take      = push && !full;
	assign cfg.n     = clamp_factor(factor_q);
	assign cfg.w     = clamp_dim(width_q, DIM_W'(MAX_WIDTH));
	assign cfg.h     = clamp_dim(height_q, DIM_W'(HEIGHT_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACT_W'(RST_FACTOR);
			width_q  <= DIM_W'(RST_WIDTH);
			height_q <= DIM_W'(RST_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SCALE:  factor_q <= cfg_data[FACT_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.take     (take),
		.pixel    (pixel),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	bfd_cmd_fifo u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	bfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.factor    (cfg.n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

`default_nettype wire

FILE: tb/box_filter_downsample_test.sv
`timescale 1ns / 1ps

module box_filter_downsample_test;
	import bfd_pkg::*;

	// Predicts the averaged pixels from the accepted input beats and checks each popped result.
	class block_mean_board;
		logic [FACT_W-1:0] factor;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		int unsigned       col_in_block;
		int unsigned       block_col;
		int unsigned       row_in_band;
		int unsigned       band;
		int unsigned       src_col;
		int unsigned       sum_red[MAX_WIDTH];
		int unsigned       sum_green[MAX_WIDTH];
		int unsigned       sum_blue[MAX_WIDTH];
		out_item_t         awaited[$];
		int unsigned       mismatches;

		function new();
			factor       = FACT_W'(RST_FACTOR);
			width        = DIM_W'(RST_WIDTH);
			height       = DIM_W'(RST_HEIGHT);
			col_in_block = 0;
			block_col    = 0;
			row_in_band  = 0;
			band         = 0;
			src_col      = 0;
			mismatches   = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [DIM_W-1:0] value);
			case (idx)
				REG_SCALE: begin
					factor = value[FACT_W-1:0];
				end
				REG_WIDTH: begin
					width = value;
				end
				REG_HEIGHT: begin
					height = value;
				end
				default: begin
				end
			endcase
		endfunction

		function logic [7:0] block_mean(int unsigned total, int unsigned area);
			int unsigned q;
			q = total / area;
			return (q > 255) ? 8'hFF : q[7:0];
		endfunction

		function void note_pixel(in_item_t px);
			int unsigned n;
			int unsigned w;
			int unsigned h;
			int unsigned cols;
			int unsigned rows;
			out_item_t   mean;
			n = (factor == 0) ? 1 : ((factor > MAX_FACTOR) ? MAX_FACTOR : factor);
			w = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
			h = (height == 0) ? 1 : ((height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height);
			cols = w / n;
			rows = h / n;
			if (px.frame_start) begin
				col_in_block = 0;
				block_col    = 0;
				row_in_band  = 0;
				band         = 0;
				src_col      = 0;
			end
			if (block_col < cols && band < rows) begin
				// The top-left pixel of a block restarts that column's sums.
				if (col_in_block == 0 && row_in_band == 0) begin
					sum_red[block_col]   = 32'(px.red_in);
					sum_green[block_col] = 32'(px.green_in);
					sum_blue[block_col]  = 32'(px.blue_in);
				end else begin
					sum_red[block_col]   += 32'(px.red_in);
					sum_green[block_col] += 32'(px.green_in);
					sum_blue[block_col]  += 32'(px.blue_in);
				end
				if (col_in_block == n - 1 && row_in_band == n - 1) begin
					mean.red_out     = block_mean(sum_red[block_col], n * n);
					mean.green_out   = block_mean(sum_green[block_col], n * n);
					mean.blue_out    = block_mean(sum_blue[block_col], n * n);
					mean.out_column  = POS_W'(block_col);
					mean.out_row     = POS_W'(band);
					mean.end_of_line = (block_col + 1 == cols);
					awaited.push_back(mean);
				end
			end
			col_in_block++;
			if (col_in_block >= n) begin
				col_in_block = 0;
				block_col++;
			end
			src_col++;
			if (src_col >= w) begin
				src_col      = 0;
				col_in_block = 0;
				block_col    = 0;
				row_in_band++;
				if (row_in_band >= n) begin
					row_in_band = 0;
					if (band < rows) begin
						band++;
					end
				end
			end
			// The band counter is only twelve bits wide and sticks at its top value.
			if (band > 4095) begin
				band = 4095;
			end
		endfunction

		function void report(string what, out_item_t want, out_item_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t %s: expected rgb %0d %0d %0d col %0d row %0d eol %0b,",
					$realtime, what, want.red_out, want.green_out, want.blue_out,
					want.out_column, want.out_row, want.end_of_line);
				$display("    got rgb %0d %0d %0d col %0d row %0d eol %0b",
					got.red_out, got.green_out, got.blue_out,
					got.out_column, got.out_row, got.end_of_line);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited.size() == 0) begin
				report("result with nothing expected", '0, got);
				return;
			end
			want = awaited.pop_front();
			if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
					got.blue_out !== want.blue_out || got.out_column !== want.out_column ||
					got.out_row !== want.out_row || got.end_of_line !== want.end_of_line) begin
				report("result mismatch", want, got);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	in_item_t          pixel;
	logic              empty;
	logic              pop;
	out_item_t         result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [DIM_W-1:0]  cfg_data;

	block_mean_board   board = new();
	int unsigned       burst_left = 0;
	bit                dense = 1'b0;
	bit                hold_request = 1'b0;

	box_filter_downsample uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Beats are seen with the values they had just before the edge.
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			board.note_pixel(pixel);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			board.check_result(result);
		end
	end

	// Receiver: stretches of different pop rates, and one long hold-off on request.
	initial begin
		int unsigned pct;
		int unsigned stretch;
		pop <= 1'b0;
		forever begin
			case ($urandom_range(0, 4))
				0, 1:    pct = 100;
				2:       pct = 75;
				3:       pct = 40;
				default: pct = 10;
			endcase
			stretch = $urandom_range(10, 150);
			repeat (stretch) begin
				@(posedge clk);
				if (hold_request) begin
					pop <= 1'b0;
					repeat (300) @(posedge clk);
					hold_request = 1'b0;
				end
				pop <= arst_n && ($urandom_range(1, 100) <= pct);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("box_filter_downsample_test failed");
		$finish;
	end

	function automatic in_item_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic fs);
		in_item_t p;
		p.red_in      = r;
		p.green_in    = g;
		p.blue_in     = b;
		p.frame_start = fs;
		return p;
	endfunction

	function automatic logic [7:0] random_channel();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_pixel(input in_item_t p);
		int unsigned gap;
		if (!dense && burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 30);
			gap = $urandom_range(1, 8);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		push  <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (full);
	endtask

	// Raster frames of w by h pixels; a noisy stream also gets stray frame starts and
	// frames that run past their end.
	task automatic send_stream(input int unsigned w, input int unsigned h,
			input int unsigned count, input bit noisy);
		int unsigned pos;
		int unsigned span;
		in_item_t    p;
		pos  = 0;
		span = w * h;
		for (int k = 0; k < count; k++) begin
			p = make_pixel(random_channel(), random_channel(), random_channel(), pos == 0);
			if (noisy && $urandom_range(0, 63) == 0) begin
				p.frame_start = 1'b1;
			end
			if (p.frame_start) begin
				pos  = 0;
				span = w * h;
				if (noisy && $urandom_range(0, 3) == 0) begin
					span += $urandom_range(1, w);
				end
			end
			send_pixel(p);
			pos++;
			if (pos >= span) begin
				pos = 0;
			end
		end
	endtask

	// Waits until every expected beat is out and the pipeline has gone quiet.
	task automatic settle();
		push <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic configure(input logic [DIM_W-1:0] f, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		logic [DIM_W-1:0] vals[3];
		reg_idx_t         idx[3];
		vals = '{f, w, h};
		idx  = '{REG_SCALE, REG_WIDTH, REG_HEIGHT};
		cfg_valid <= 1'b1;
		for (int k = 0; k < 3; k++) begin
			cfg_index <= idx[k];
			cfg_data  <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			board.set_register(idx[k], vals[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned n;
		int unsigned w;
		int unsigned h;
		int unsigned count;
		int unsigned random_sent;
		arst_n    <= 1'b0;
		push      <= 1'b0;
		pixel     <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_SCALE;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry is far too large to finish a block here; these only move counters.
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b1));
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
		send_pixel(make_pixel(8'h55, 8'hAA, 8'h0F, 1'b0));
		send_pixel(make_pixel(8'hAA, 8'h55, 8'hF0, 1'b0));

		// Zero registers act as one: one pixel per frame, the rest ignored until frame start.
		settle();
		configure('0, '0, '0);
		send_pixel(make_pixel(8'hFF, 8'h00, 8'h80, 1'b1));
		send_pixel(make_pixel(8'h00, 8'hFF, 8'h01, 1'b0));
		send_pixel(make_pixel(8'h00, 8'hFF, 8'h7F, 1'b1));
		send_pixel(make_pixel(8'h12, 8'h34, 8'h56, 1'b0));

		// Two blocks per band, with a trailing column and a trailing line left over.
		settle();
		configure(DIM_W'(2), DIM_W'(5), DIM_W'(3));
		for (int k = 0; k < 15; k++) begin
			send_pixel(make_pixel((k % 5 < 2) ? 8'hFF : 8'h01, 8'(k * 17), ~8'(k * 17),
				k == 0));
		end

		// Factor above the limit saturates at sixteen.
		settle();
		configure('1, DIM_W'(17), DIM_W'(33));
		send_stream(17, 33, 290, 1'b0);

		// Width above the limit, one result per beat, while the receiver holds off.
		settle();
		configure(DIM_W'(1), '1, DIM_W'(1));
		dense        = 1'b1;
		hold_request = 1'b1;
		send_stream(4096, 1, 200, 1'b0);
		dense = 1'b0;

		// A single column with the height register above the limit.
		settle();
		configure(DIM_W'(1), DIM_W'(1), '1);
		send_stream(1, 4096, 60, 1'b0);

		random_sent = 0;
		while (random_sent < 560) begin
			if ($urandom_range(0, 5) == 0) begin
				n = $urandom_range(7, 16);
				w = n + $urandom_range(0, 2 * n);
				h = n + $urandom_range(0, n - 1);
			end else begin
				n = $urandom_range(1, 6);
				w = n * $urandom_range(1, 5) + $urandom_range(0, n - 1);
				h = n * $urandom_range(1, 3) + $urandom_range(0, n - 1);
			end
			count = $urandom_range(60, 200);
			settle();
			configure(DIM_W'(n), DIM_W'(w), DIM_W'(h));
			send_stream(w, h, count, 1'b1);
			random_sent += count;
		end

		settle();
		if (board.mismatches == 0 && board.awaited.size() == 0) begin
			$display("box_filter_downsample_test passed");
		end else begin
			$display("box_filter_downsample_test failed");
		end
		$finish;
	end

endmodule
